### rtl/core/sct_pkg.sv
package sct_pkg;

  localparam int MIN_W  = 7;
  localparam int SEC_W  = 6;
  localparam int CNT_W  = 16;
  localparam int DEB_W  = 8;
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;

  localparam logic [MIN_W-1:0] MAX_MINUTES  = 7'd99;
  localparam logic [SEC_W-1:0] MAX_SECONDS  = 6'd59;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [CNT_W-1:0] SECOND_RST   = 16'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_PULSE  = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_MIN  = 3'b010,
    MODE_SEC  = 3'b100
  } mode_t;

  localparam logic [MODE_W-1:0] CODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] CODE_MIN  = 2'd1;
  localparam logic [MODE_W-1:0] CODE_SEC  = 2'd2;

  typedef enum logic [0:0] {
    REG_DEBOUNCE = 1'b0,
    REG_SECOND   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [MIN_W-1:0] minute_count;
    logic [SEC_W-1:0] second_count;
    mode_t            mode;
    logic [MIN_W-1:0] knob_position;
    logic [CNT_W-1:0] ms_since_pulse;
    logic [CNT_W-1:0] ms_in_second;
  } state_t;

  typedef struct packed {
    logic store_minutes;
    logic store_seconds;
    logic refresh_display;
  } strobe_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_IDLE: c = CODE_IDLE;
      MODE_MIN:  c = CODE_MIN;
      MODE_SEC:  c = CODE_SEC;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/sct_next.sv
module sct_next (
  input  sct_pkg::state_t                 cur,
  input  logic [sct_pkg::OP_W-1:0]        opcode,
  input  logic                            direction,
  input  logic [sct_pkg::DEB_W-1:0]       debounce_ms,
  input  logic [sct_pkg::CNT_W-1:0]       second_ms,
  output sct_pkg::state_t                 nxt,
  output sct_pkg::strobe_t                strobes
);
  import sct_pkg::*;

  always_comb begin
    logic [CNT_W-1:0] ms_inc;
    logic [MIN_W-1:0] knob_new;
    logic             debounced;
    nxt      = cur;
    strobes  = '0;
    ms_inc   = (cur.ms_in_second != '1) ? cur.ms_in_second + 1'b1 : cur.ms_in_second;
    knob_new = cur.knob_position;
    debounced = cur.ms_since_pulse > {{(CNT_W-DEB_W){1'b0}}, debounce_ms};
    unique case (opcode_t'(opcode))
      OP_TICK: begin
        if (cur.ms_since_pulse != '1) begin
          nxt.ms_since_pulse = cur.ms_since_pulse + 1'b1;
        end
        if (ms_inc >= second_ms) begin
          nxt.ms_in_second = '0;
          if (cur.second_count == '0) begin
            if (cur.minute_count != '0) begin
              nxt.second_count = MAX_SECONDS;
              nxt.minute_count = cur.minute_count - 1'b1;
            end
          end else begin
            nxt.second_count = cur.second_count - 1'b1;
          end
          strobes.refresh_display = (cur.mode == MODE_IDLE);
        end else begin
          nxt.ms_in_second = ms_inc;
        end
      end
      OP_PULSE: begin
        nxt.ms_since_pulse = '0;
        if (debounced && cur.mode == MODE_MIN) begin
          if (direction) begin
            knob_new = (cur.knob_position < MAX_MINUTES) ?
                       cur.knob_position + 1'b1 : MAX_MINUTES;
          end else if (cur.knob_position > MAX_MINUTES) begin
            knob_new = MAX_MINUTES;
          end else if (cur.knob_position != '0) begin
            knob_new = cur.knob_position - 1'b1;
          end
          nxt.knob_position = knob_new;
          nxt.minute_count  = knob_new;
        end else if (debounced && cur.mode == MODE_SEC) begin
          if (direction) begin
            if (cur.knob_position >= {1'b0, MAX_SECONDS}) begin
              knob_new = '0;
              if (cur.minute_count < MAX_MINUTES) begin
                nxt.minute_count = cur.minute_count + 1'b1;
              end
            end else begin
              knob_new = cur.knob_position + 1'b1;
            end
          end else begin
            if (cur.knob_position == '0) begin
              knob_new = {1'b0, MAX_SECONDS};
              if (cur.minute_count != '0) begin
                nxt.minute_count = cur.minute_count - 1'b1;
              end
            end else if (cur.knob_position > {1'b0, MAX_SECONDS}) begin
              knob_new = {1'b0, MAX_SECONDS};
            end else begin
              knob_new = cur.knob_position - 1'b1;
            end
          end
          nxt.knob_position = knob_new;
          nxt.second_count  = knob_new[SEC_W-1:0];
        end
      end
      OP_BUTTON: begin
        unique case (cur.mode)
          MODE_IDLE: begin
            nxt.mode          = MODE_MIN;
            nxt.knob_position = cur.minute_count;
          end
          MODE_MIN: begin
            nxt.mode              = MODE_SEC;
            nxt.knob_position     = {1'b0, cur.second_count};
            strobes.store_minutes = 1'b1;
          end
          MODE_SEC: begin
            nxt.mode              = MODE_IDLE;
            strobes.store_seconds = 1'b1;
          end
          default: nxt.mode = MODE_IDLE;
        endcase
      end
      OP_NONE: ;
    endcase
  end

endmodule

### rtl/core/settable_countdown_timer_top.sv
// Minutes:seconds countdown timer with encoder/button time setting.
// The result of an input transfer is registered and appears on the master side in the next cycle.
// Throughput: one item per cycle while the master side accepts results; the state update
// is combinational logic and the result register frees whenever the master side takes its transfer.
// Reset (rst, synchronous): time 00:00, idle, debounce_ms 10, second_ms 1000.
module settable_countdown_timer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] direction
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [6:0] minutes, [12:7] seconds, [14:13] set_mode,
                                     // [15] store_minutes, [16] store_seconds,
                                     // [17] refresh_display
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sct_pkg::*;

  state_t             state;
  state_t             state_next;
  strobe_t            strobes;
  logic [DEB_W-1:0]   debounce_ms;
  logic [CNT_W-1:0]   second_ms;
  logic               in_xfer;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  sct_next u_next (
    .cur         (state),
    .opcode      (s_axis_tuser),
    .direction   (s_axis_tdata[0]),
    .debounce_ms (debounce_ms),
    .second_ms   (second_ms),
    .nxt         (state_next),
    .strobes     (strobes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.minute_count   <= '0;
      state.second_count   <= '0;
      state.mode           <= MODE_IDLE;
      state.knob_position  <= '0;
      state.ms_since_pulse <= '1;
      state.ms_in_second   <= '0;
      debounce_ms          <= DEBOUNCE_RST;
      second_ms            <= SECOND_RST;
      m_axis_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DEBOUNCE: debounce_ms <= cfg_data[DEB_W-1:0];
          REG_SECOND:   second_ms   <= cfg_data[CNT_W-1:0];
        endcase
      end
      if (in_xfer) begin
        state         <= state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= {6'b0,
                       strobes.refresh_display,
                       strobes.store_seconds,
                       strobes.store_minutes,
                       mode_code(state_next.mode),
                       state_next.second_count,
                       state_next.minute_count};
    end
  end

  a_store_min_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[14:13] == CODE_SEC)
    else $error("minutes store strobe outside seconds mode");

  a_store_sec_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16] || m_axis_tdata[17]) |->
      m_axis_tdata[14:13] == CODE_IDLE)
    else $error("seconds store or refresh outside idle");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:0] <= MAX_MINUTES && m_axis_tdata[12:7] <= MAX_SECONDS)
    else $error("time out of range");

  a_pulse_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_axis_tuser == OP_PULSE |=> state.ms_since_pulse == '0)
    else $error("pulse did not clear debounce timer");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_axis_tvalid)
    else $error("accepted item produced no result");

endmodule
